/* rtl/cfp_pkg.sv */
// Shared constants, codes and types of the CRC-checked packet FIFO.
package cfp_pkg;

  // Default geometry of the packet ring.
  localparam int unsigned PACKET_BYTES_DEF = 16;
  localparam int unsigned QUEUE_SLOTS_DEF  = 8;

  // Trailing bytes that carry the received checksum.
  localparam int unsigned CHECK_BYTES = 4;

  // Reflected CRC-32 polynomial and start value.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Slot field of a command, wide enough for the largest ring.
  localparam int unsigned SLOT_FIELD_W = 6;
  typedef logic [SLOT_FIELD_W-1:0] slot_t;

  // Request codes on the input side.
  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_EOT  = 2'd1,
    MODE_POP  = 2'd2
  } mode_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  // Transfer status codes.
  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_SHORT = 3'd2,
    ST_LONG  = 3'd3,
    ST_CRC   = 3'd4
  } status_e;

  // Commands handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,
    CMD_POP    = 2'd1,
    CMD_EMPTY  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    status_e   status;
    slot_t     slot;
  } cmd_t;

  // One result as it sits in the output register.
  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [7:0]  pbyte;
    logic        last;
  } result_t;

  // Back end state, one-hot.
  typedef enum logic [1:0] {
    B_IDLE   = 2'b01,
    B_STREAM = 2'b10
  } back_state_e;

  // Status reported by the back end to the front end.
  typedef struct packed {
    logic streaming;
  } back_stat_t;

endpackage

/* rtl/cfp_front.sv */
// Front end: accepts requests, runs the CRC, writes bytes and issues commands.
module cfp_front #(
  parameter int unsigned PACKET_BYTES = 16,
  parameter int unsigned QUEUE_SLOTS  = 8,
  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * PACKET_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          data_byte_i,
  input  logic                cmd_full_i,
  input  logic                cmd_empty_i,
  input  cfp_pkg::back_stat_t back_stat_i,
  output logic                cmd_push_o,
  output cfp_pkg::cmd_t       cmd_o,
  output logic                wr_en_o,
  output logic [ADDR_W-1:0]   wr_addr_o,
  output logic [7:0]          wr_data_o
);
  import cfp_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(PACKET_BYTES + 2);
  localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(PACKET_BYTES);
  localparam logic [CNT_W-1:0]  CNT_SAT     = CNT_W'(PACKET_BYTES + 1);
  localparam logic [CNT_W-1:0]  CNT_CRC_END = CNT_W'(PACKET_BYTES - CHECK_BYTES);
  localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [ADDR_W-1:0] STRIDE      = ADDR_W'(PACKET_BYTES);

  // One byte step of the reflected CRC, bit by bit.
  function automatic logic [31:0] crc32_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [SLOT_W-1:0] head_next, tail_next;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [31:0]       crc_q, crc_d, chk_q, chk_d;
  logic              accept;

  // A received byte waits while a pop may still read the packet store.
  assign full = cmd_full_i ||
                ((mode_i == MODE_BYTE) && (!cmd_empty_i || back_stat_i.streaming));
  assign accept = push && !full;

  assign head_next = (head_q == SLOT_LAST) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == SLOT_LAST) ? '0 : tail_q + 1'b1;

  // Store write port: tail slot, current byte position.
  assign wr_addr_o = ADDR_W'(tail_q) * STRIDE + ADDR_W'(cnt_q);
  assign wr_data_o = data_byte_i;

  // Request handling.
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    chk_d      = chk_q;
    wr_en_o    = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: CMD_STATUS, status: ST_OK, slot: '0};
    if (accept) begin
      case (mode_i)
        MODE_BYTE: begin
          if (cnt_q < CNT_FULL) begin
            wr_en_o = 1'b1;
            if (cnt_q < CNT_CRC_END) begin
              crc_d = crc32_byte(crc_q, data_byte_i);
            end else begin
              chk_d = {chk_q[23:0], data_byte_i};
            end
            cnt_d = cnt_q + 1'b1;
          end else begin
            cnt_d = CNT_SAT;
          end
        end
        MODE_EOT: begin
          cmd_push_o = 1'b1;
          if (tail_next == head_q) begin
            cmd_o.status = ST_FULL;
          end else if (cnt_q < CNT_FULL) begin
            cmd_o.status = ST_SHORT;
          end else if (cnt_q > CNT_FULL) begin
            cmd_o.status = ST_LONG;
          end else if (~crc_q != chk_q) begin
            cmd_o.status = ST_CRC;
          end else begin
            cmd_o.status = ST_OK;
            tail_d = tail_next;
          end
          cnt_d = '0;
          crc_d = CRC_INIT;
          chk_d = '0;
        end
        MODE_POP: begin
          cmd_push_o = 1'b1;
          if (head_q == tail_q) begin
            cmd_o.kind = CMD_EMPTY;
          end else begin
            cmd_o.kind = CMD_POP;
            cmd_o.slot = slot_t'(head_q);
            head_d     = head_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Ring pointers and transfer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
      crc_q  <= CRC_INIT;
      chk_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      chk_q  <= chk_d;
    end
  end

endmodule

/* rtl/cfp_cmd_queue.sv */
// Two-entry command queue between the front end and the back end.
module cfp_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfp_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output cfp_pkg::cmd_t cmd_o,
  output logic          full_o,
  output logic          empty_o
);
  import cfp_pkg::*;

  cmd_t       entries_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/cfp_back.sv */
// Back end: packet store, pop streaming and the output register.
module cfp_back #(
  parameter int unsigned PACKET_BYTES = 16,
  parameter int unsigned QUEUE_SLOTS  = 8,
  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * PACKET_BYTES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  logic [7:0]          wr_data_i,
  input  cfp_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output cfp_pkg::back_stat_t back_stat_o,
  input  logic                pop,
  output logic                empty,
  output logic [1:0]          kind_o,
  output logic [2:0]          status_o,
  output logic [7:0]          packet_byte_o,
  output logic                last_o
);
  import cfp_pkg::*;

  localparam int unsigned SLOT_W = $clog2(QUEUE_SLOTS);
  localparam int unsigned IDX_W  = $clog2(PACKET_BYTES);
  localparam int unsigned DEPTH  = QUEUE_SLOTS * PACKET_BYTES;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(PACKET_BYTES - 1);
  localparam logic [ADDR_W-1:0] STRIDE   = ADDR_W'(PACKET_BYTES);

  logic [7:0]        mem_q [DEPTH];
  back_state_e       state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              rd_v_q, rd_v_d, rd_last_q, rd_last_d, rd_issue;
  logic [7:0]        rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              out_valid_q, out_valid_d, out_load, out_free;
  result_t           out_q, out_d;

  assign rd_addr  = ADDR_W'(slot_q) * STRIDE + ADDR_W'(idx_q);
  assign out_free = !out_valid_q || pop;

  // Packet store with a registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_issue) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Command execution and result selection.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    rd_v_d    = rd_v_q;
    rd_last_d = rd_last_q;
    rd_issue  = 1'b0;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    out_d     = out_q;

    // A fetched byte moves on as soon as the output register frees up.
    if (rd_v_q && out_free) begin
      out_load = 1'b1;
      out_d    = '{kind: KIND_BYTE, status: ST_OK, pbyte: rd_data_q, last: rd_last_q};
      rd_v_d   = 1'b0;
    end

    case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i && !rd_v_q) begin
          if (cmd_i.kind == CMD_POP) begin
            cmd_pop_o = 1'b1;
            state_d   = B_STREAM;
            slot_d    = SLOT_W'(cmd_i.slot);
            idx_d     = '0;
          end else if (out_free) begin
            cmd_pop_o = 1'b1;
            out_load  = 1'b1;
            if (cmd_i.kind == CMD_EMPTY) begin
              out_d = '{kind: KIND_EMPTY, status: ST_OK, pbyte: 8'h00, last: 1'b1};
            end else begin
              out_d = '{kind: KIND_STATUS, status: cmd_i.status, pbyte: 8'h00,
                        last: 1'b1};
            end
          end
        end
      end
      B_STREAM: begin
        if (!rd_v_q || out_free) begin
          rd_issue  = 1'b1;
          rd_v_d    = 1'b1;
          rd_last_d = (idx_q == IDX_LAST);
          idx_d     = idx_q + 1'b1;
          if (idx_q == IDX_LAST) begin
            state_d = B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_v_q      <= rd_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    slot_q    <= slot_d;
    rd_last_q <= rd_last_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign back_stat_o.streaming = (state_q == B_STREAM);
  assign empty         = !out_valid_q;
  assign kind_o        = out_q.kind;
  assign status_o      = out_q.status;
  assign packet_byte_o = out_q.pbyte;
  assign last_o        = out_q.last;

endmodule

/* rtl/crc_checked_packet_fifo_top.sv */
// Top level of the CRC-checked packet FIFO.
//
//   Channel   Handshake         Payload
//   request   push / full       mode_i, data_byte_i
//   result    empty / pop       kind_o, status_o, packet_byte_o, last_o
//
// A request is taken while full is low; a status or empty result then passes through the
// command queue and the output register. A stored packet's PACKET_BYTES results leave one
// per cycle while the result side pops, through the store's registered read port.
// Received bytes are held off (full) while any command waits or a pop still reads the store.
// Every request is held off while the two-entry command queue is full.
// Reset is asynchronous; the packet store needs no clearing pass.
module crc_checked_packet_fifo_top #(
  parameter int unsigned PACKET_BYTES = cfp_pkg::PACKET_BYTES_DEF,
  parameter int unsigned QUEUE_SLOTS  = cfp_pkg::QUEUE_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode_i,
  input  logic [7:0] data_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [2:0] status_o,
  output logic [7:0] packet_byte_o,
  output logic       last_o
);
  import cfp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(QUEUE_SLOTS * PACKET_BYTES);

  cmd_t              cmd_in, cmd_out;
  logic              cmd_push, cmd_pop, cmd_full, cmd_empty;
  back_stat_t        back_stat;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  // Request side.
  cfp_front #(
    .PACKET_BYTES(PACKET_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .mode_i     (mode_i),
    .data_byte_i(data_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_empty_i(cmd_empty),
    .back_stat_i(back_stat),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // Decoupling queue.
  cfp_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd_in),
    .pop_i  (cmd_pop),
    .cmd_o  (cmd_out),
    .full_o (cmd_full),
    .empty_o(cmd_empty)
  );

  // Result side.
  cfp_back #(
    .PACKET_BYTES(PACKET_BYTES),
    .QUEUE_SLOTS (QUEUE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (wr_en),
    .wr_addr_i    (wr_addr),
    .wr_data_i    (wr_data),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .back_stat_o  (back_stat),
    .pop          (pop),
    .empty        (empty),
    .kind_o       (kind_o),
    .status_o     (status_o),
    .packet_byte_o(packet_byte_o),
    .last_o       (last_o)
  );

endmodule

/* rtl/cfp_checker.sv */
// Port-level checks of the CRC-checked packet FIFO, bound to the top level.
module cfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [1:0] kind_o,
  input logic [2:0] status_o,
  input logic [7:0] packet_byte_o,
  input logic       last_o
);
  import cfp_pkg::*;

  // Only the three defined result kinds appear.
  a_kind_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (kind_o == KIND_STATUS || kind_o == KIND_BYTE || kind_o == KIND_EMPTY))
    else $error("undefined result kind");

  // Status and empty results are single results and close their request.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BYTE) |-> last_o)
    else $error("single result without last");

  // The status field is zero outside status results.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_STATUS) |-> (status_o == ST_OK))
    else $error("status set outside a status result");

  // The byte field is zero outside byte results.
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_BYTE) |-> (packet_byte_o == 8'h00))
    else $error("packet byte set outside a byte result");

  // A packet stream is not interrupted by other results.
  a_stream_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && kind_o == KIND_BYTE && !last_o) |=> (empty || kind_o == KIND_BYTE))
    else $error("packet stream interrupted");

endmodule

bind crc_checked_packet_fifo_top cfp_checker u_cfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .kind_o       (kind_o),
  .status_o     (status_o),
  .packet_byte_o(packet_byte_o),
  .last_o       (last_o)
);

/* tb/crc_checked_packet_fifo_top_tb.sv */
// Self-checking testbench for the CRC-checked packet FIFO: a directed script, random traffic.
module crc_checked_packet_fifo_top_tb;
  import cfp_pkg::*;

  localparam int unsigned PACKET_LEN   = PACKET_BYTES_DEF;
  localparam int unsigned RING_SLOTS   = QUEUE_SLOTS_DEF;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 30;
  // End-of-transfer requests sent back to back while the receiver holds off.
  localparam int unsigned BURST_ITEMS  = 4;
  // The receiver holds off once for this long while requests keep coming.
  localparam int unsigned HOLD_CYCLES  = 200;
  // Cycles allowed after the last result for stray results to show up.
  localparam int unsigned DRAIN_CYCLES = 40;
  // Longest legal stretch without any handshake is the hold-off; the limit is set above that.
  localparam int unsigned STALL_LIMIT  = 2000;

  // Kinds of rows in the directed script.
  typedef enum {ROW_BYTE, ROW_EOT, ROW_POP, ROW_UNUSED, ROW_XFER} row_op_e;

  typedef struct {
    row_op_e     op;
    logic [7:0]  data;
    int unsigned len;
    bit          use_fill;
    bit          corrupt;
    int unsigned reps;
    bit          typed;
    kind_e       exp_kind;
    status_e     exp_status;
  } row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic       full;
  logic [1:0] mode_i      = 2'd0;
  logic [7:0] data_byte_i = 8'h00;
  logic       empty;
  logic       pop         = 1'b0;
  logic [1:0] kind_o;
  logic [2:0] status_o;
  logic [7:0] packet_byte_o;
  logic       last_o;

  // Shadow copy of the packet ring and the receive state.
  logic [7:0]  ring_mem [RING_SLOTS*PACKET_LEN];
  int unsigned ring_head = 0;
  int unsigned ring_tail = 0;
  int unsigned rx_count  = 0;
  logic [31:0] rx_crc    = CRC_INIT;
  logic [31:0] rx_check  = 32'h0;

  result_t     awaited_results [$];
  int unsigned requests_sent  = 0;
  int unsigned results_taken  = 0;
  int unsigned mismatches     = 0;
  int unsigned stall_cycles   = 0;
  bit          random_phase   = 1'b0;

  // Directed script; typed-in results only where they are obvious.
  row_t script [12] = '{
    '{ROW_POP,    8'h00, 0,  0, 0, 1, 1, KIND_EMPTY,  ST_OK},
    '{ROW_EOT,    8'h00, 0,  0, 0, 1, 1, KIND_STATUS, ST_SHORT},
    '{ROW_UNUSED, 8'hFF, 0,  0, 0, 1, 0, KIND_STATUS, ST_OK},
    '{ROW_BYTE,   8'h00, 0,  0, 0, 1, 0, KIND_STATUS, ST_OK},
    '{ROW_BYTE,   8'hFF, 0,  0, 0, 1, 0, KIND_STATUS, ST_OK},
    '{ROW_EOT,    8'h00, 0,  0, 0, 1, 1, KIND_STATUS, ST_SHORT},
    '{ROW_XFER,   8'h00, 15, 0, 0, 1, 1, KIND_STATUS, ST_SHORT},
    '{ROW_XFER,   8'h00, 20, 0, 0, 1, 1, KIND_STATUS, ST_LONG},
    '{ROW_XFER,   8'h00, 16, 0, 1, 1, 1, KIND_STATUS, ST_CRC},
    '{ROW_XFER,   8'hFF, 16, 1, 0, 1, 1, KIND_STATUS, ST_OK},
    '{ROW_POP,    8'h00, 0,  0, 0, 1, 0, KIND_STATUS, ST_OK},
    '{ROW_POP,    8'h00, 0,  0, 0, 1, 1, KIND_EMPTY,  ST_OK}
  };

  crc_checked_packet_fifo_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .status_o      (status_o),
    .packet_byte_o (packet_byte_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // One step of the reflected CRC-32, least significant bit first.
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    int          i;
    c = crc ^ {24'h0, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Applies one accepted request to the shadow ring and lists the results it causes.
  function automatic void advance_packet_ring(input logic [1:0] mode, input logic [7:0] data,
                                              ref result_t produced[$]);
    int unsigned next_slot;
    status_e     st;
    int unsigned k;
    produced.delete();
    case (mode)
      MODE_BYTE: begin
        if (rx_count < PACKET_LEN) begin
          ring_mem[ring_tail*PACKET_LEN + rx_count] = data;
          if (rx_count < PACKET_LEN - CHECK_BYTES) begin
            rx_crc = crc32_shift_byte(rx_crc, data);
          end else begin
            rx_check = {rx_check[23:0], data};
          end
          rx_count++;
        end else begin
          rx_count = PACKET_LEN + 1;
        end
      end
      MODE_EOT: begin
        next_slot = (ring_tail + 1) % RING_SLOTS;
        if (next_slot == ring_head) begin
          st = ST_FULL;
        end else if (rx_count < PACKET_LEN) begin
          st = ST_SHORT;
        end else if (rx_count > PACKET_LEN) begin
          st = ST_LONG;
        end else if (~rx_crc != rx_check) begin
          st = ST_CRC;
        end else begin
          st = ST_OK;
          ring_tail = next_slot;
        end
        rx_count = 0;
        rx_crc   = CRC_INIT;
        rx_check = 32'h0;
        produced.push_back('{KIND_STATUS, st, 8'h00, 1'b1});
      end
      MODE_POP: begin
        if (ring_head == ring_tail) begin
          produced.push_back('{KIND_EMPTY, ST_OK, 8'h00, 1'b1});
        end else begin
          for (k = 0; k < PACKET_LEN; k++) begin
            produced.push_back('{KIND_BYTE, ST_OK, ring_mem[ring_head*PACKET_LEN + k],
                                 (k == PACKET_LEN - 1)});
          end
          ring_head = (ring_head + 1) % RING_SLOTS;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Builds the bytes of one transfer: a valid packet, optionally damaged, cut or padded.
  function automatic void build_transfer(input int unsigned len, input bit use_fill,
                                         input logic [7:0] fill, input bit corrupt,
                                         ref logic [7:0] bytes[$]);
    logic [31:0] crc;
    logic [31:0] chk;
    logic [7:0]  b;
    int unsigned i;
    int unsigned pos;
    bytes.delete();
    crc = CRC_INIT;
    for (i = 0; i < PACKET_LEN - CHECK_BYTES; i++) begin
      b = use_fill ? fill : 8'($urandom_range(255));
      bytes.push_back(b);
      crc = crc32_shift_byte(crc, b);
    end
    chk = ~crc;
    for (i = 0; i < CHECK_BYTES; i++) begin
      bytes.push_back(chk[31-8*i -: 8]);
    end
    // A single flipped bit always breaks the checksum.
    if (corrupt) begin
      pos = $urandom_range(PACKET_LEN - 1);
      bytes[pos] = bytes[pos] ^ (8'h01 << $urandom_range(7));
    end
    while (bytes.size() > len) begin
      void'(bytes.pop_back());
    end
    while (bytes.size() < len) begin
      bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  // Offers one request, waits for it to be taken and records its expected results.
  task automatic offer_request(input logic [1:0] m, input logic [7:0] d, input bit typed,
                               input result_t typed_res);
    result_t produced [$];
    if (requests_sent < 20 || requests_sent >= 60) begin
      while ($urandom_range(99) < 16) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push        <= 1'b1;
    mode_i      <= m;
    data_byte_i <= d;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    advance_packet_ring(m, d, produced);
    if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      foreach (produced[i]) begin
        awaited_results.push_back(produced[i]);
      end
    end
    if (m != MODE_UNUSED) begin
      requests_sent++;
    end
  endtask

  // Sends the bytes of one transfer followed by its end of transfer.
  task automatic offer_transfer(input int unsigned len, input bit use_fill, input logic [7:0] fill,
                                input bit corrupt, input bit typed, input result_t eot_res);
    logic [7:0] bytes [$];
    build_transfer(len, use_fill, fill, corrupt, bytes);
    foreach (bytes[i]) begin
      offer_request(MODE_BYTE, bytes[i], 1'b0, '0);
    end
    offer_request(MODE_EOT, 8'($urandom_range(255)), typed, eot_res);
  endtask

  // Compares one taken result with the oldest expectation.
  function automatic void check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      $error("unexpected result: kind %0d status %0d byte %0h last %0d",
             kind_o, status_o, packet_byte_o, last_o);
      mismatches++;
      return;
    end
    want = awaited_results.pop_front();
    if (kind_o !== want.kind) begin
      $error("kind_o: expected %0d, got %0d", want.kind, kind_o);
      mismatches++;
    end
    if (status_o !== want.status) begin
      $error("status_o: expected %0d, got %0d", want.status, status_o);
      mismatches++;
    end
    if (packet_byte_o !== want.pbyte) begin
      $error("packet_byte_o: expected %0h, got %0h", want.pbyte, packet_byte_o);
      mismatches++;
    end
    if (last_o !== want.last) begin
      $error("last_o: expected %0d, got %0d", want.last, last_o);
      mismatches++;
    end
  endfunction

  // Result side: random pops, one long hold-off, a quiet stretch without gaps.
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && random_phase) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      pop <= (results_taken >= 4 && results_taken < 24) || ($urandom_range(99) >= 16);
      @(posedge clk_i);
      if (pop && !empty) begin
        check_result();
        results_taken++;
      end
    end
  end

  // Watchdog: ends the run when no request and no result moves for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("crc_checked_packet_fifo_top: mismatch");
    $finish;
  end

  // Request side: reset, directed script, random traffic, then drain.
  initial begin
    result_t     row_res;
    int unsigned rand_start;
    int unsigned pick;
    int unsigned len;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[r]) begin
      row_res = '{script[r].exp_kind, script[r].exp_status, 8'h00, 1'b1};
      repeat (script[r].reps) begin
        case (script[r].op)
          ROW_BYTE:   offer_request(MODE_BYTE, script[r].data, 1'b0, '0);
          ROW_UNUSED: offer_request(MODE_UNUSED, script[r].data, 1'b0, '0);
          ROW_EOT:    offer_request(MODE_EOT, script[r].data, script[r].typed, row_res);
          ROW_POP:    offer_request(MODE_POP, script[r].data, script[r].typed, row_res);
          default:    offer_transfer(script[r].len, script[r].use_fill, script[r].data,
                                     script[r].corrupt, script[r].typed, row_res);
        endcase
      end
    end

    // Mostly well-formed transfers with random content; pops are rarer so the ring fills.
    random_phase = 1'b1;
    rand_start   = requests_sent;
    // The receiver holds off now, so a burst of end-of-transfer requests fills the block.
    repeat (BURST_ITEMS) begin
      offer_request(MODE_EOT, 8'($urandom_range(255)), 1'b0, '0);
    end
    while (requests_sent < rand_start + RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        offer_transfer(PACKET_LEN, 1'b0, 8'h00, 1'b0, 1'b0, '0);
      end else if (pick < 65) begin
        offer_transfer(PACKET_LEN, 1'b0, 8'h00, 1'b1, 1'b0, '0);
      end else if (pick < 72) begin
        len = $urandom_range(1) ? $urandom_range(PACKET_LEN - 1)
                                : $urandom_range(PACKET_LEN + 8, PACKET_LEN + 1);
        offer_transfer(len, 1'b0, 8'h00, 1'b0, 1'b0, '0);
      end else if (pick < 88) begin
        offer_request(MODE_POP, 8'($urandom_range(255)), 1'b0, '0);
      end else if (pick < 94) begin
        offer_request(2'($urandom_range(3)), 8'($urandom_range(255)), 1'b0, '0);
      end else begin
        offer_request(MODE_EOT, 8'($urandom_range(255)), 1'b0, '0);
      end
    end
    push <= 1'b0;

    while (awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("crc_checked_packet_fifo_top: match");
    end else begin
      $display("crc_checked_packet_fifo_top: mismatch");
    end
    $finish;
  end

endmodule

/* crc_checked_packet_fifo_top.f */
rtl/cfp_pkg.sv
rtl/cfp_front.sv
rtl/cfp_cmd_queue.sv
rtl/cfp_back.sv
rtl/crc_checked_packet_fifo_top.sv
rtl/cfp_checker.sv
tb/crc_checked_packet_fifo_top_tb.sv
